### src/pft_pkg.sv
`default_nettype none

package pft_pkg;

  localparam int FRAMES     = 16;
  localparam int FRAME_W    = $clog2(FRAMES);
  localparam int CNT_W      = $clog2(FRAMES + 1);
  localparam int PID_W      = 16;
  localparam int PAGE_W     = 32;
  localparam int STAMP_W    = 32;
  localparam int ADDR_W     = 32;
  localparam int FUNC_W     = 2;
  localparam int SHIFT_W    = 5;
  localparam int LIMIT_W    = 5;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 5;
  localparam int IN_W       = 56;
  localparam int OUT_W      = 80;

  localparam logic [FUNC_W-1:0] FUNC_NEW    = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_ACCESS = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_TERM   = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_PAGE_SHIFT  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_LIMIT = 1'b1;

  typedef struct packed {
    logic clear;
    logic track;
  } scan_ctrl_t;

  typedef struct packed {
    logic               pid_eq;
    logic               page_eq;
    logic               found;
    logic [FRAME_W-1:0] best_idx;
  } scan_stat_t;

endpackage

`default_nettype wire

### src/pft_free_q.sv
`default_nettype none

module pft_free_q (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        push,
  input  wire logic [pft_pkg::FRAME_W-1:0] push_frame,
  input  wire logic                        pop,
  output logic      [pft_pkg::FRAME_W-1:0] head_frame,
  output logic      [pft_pkg::CNT_W-1:0]   count
);
  import pft_pkg::*;

  logic [FRAME_W-1:0] mem_r [FRAMES];
  logic [FRAME_W-1:0] head_r;
  logic [FRAME_W-1:0] head_nxt;
  logic [CNT_W-1:0]   count_r;
  logic [CNT_W-1:0]   count_nxt;
  logic [FRAME_W:0]   tail_sum;
  logic [FRAME_W-1:0] tail;
  logic               push_ok;
  logic               pop_ok;

  always_comb begin
    tail_sum = {1'b0, head_r} + (FRAME_W + 1)'(count_r);
    if (tail_sum >= (FRAME_W + 1)'(FRAMES)) begin
      tail_sum = tail_sum - (FRAME_W + 1)'(FRAMES);
    end
    tail = tail_sum[FRAME_W-1:0];
  end

  assign push_ok = push && (count_r < CNT_W'(FRAMES));
  assign pop_ok  = pop && (count_r != '0);

  always_comb begin
    head_nxt  = head_r;
    count_nxt = count_r;
    if (pop_ok) begin
      head_nxt  = (head_r == FRAME_W'(FRAMES - 1)) ? '0 : head_r + FRAME_W'(1);
      count_nxt = count_nxt - CNT_W'(1);
    end
    if (push_ok) begin
      count_nxt = count_nxt + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      mem_r[tail] <= push_frame;
    end
  end

  assign head_frame = mem_r[head_r];
  assign count      = count_r;

endmodule

`default_nettype wire

### src/pft_scan_unit.sv
`default_nettype none

module pft_scan_unit (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire pft_pkg::scan_ctrl_t         ctrl,
  input  wire logic [pft_pkg::FRAME_W-1:0] idx,
  input  wire logic                        ent_valid,
  input  wire logic [pft_pkg::PID_W-1:0]   ent_pid,
  input  wire logic [pft_pkg::PAGE_W-1:0]  ent_page,
  input  wire logic [pft_pkg::STAMP_W-1:0] ent_stamp,
  input  wire logic [pft_pkg::PID_W-1:0]   key_pid,
  input  wire logic [pft_pkg::PAGE_W-1:0]  key_page,
  output pft_pkg::scan_stat_t              stat,
  output logic      [pft_pkg::PID_W-1:0]   vic_pid,
  output logic      [pft_pkg::PAGE_W-1:0]  vic_page
);
  import pft_pkg::*;

  logic               found_r;
  logic [FRAME_W-1:0] best_idx_r;
  logic [STAMP_W-1:0] best_stamp_r;
  logic [PID_W-1:0]   best_pid_r;
  logic [PAGE_W-1:0]  best_page_r;
  logic               older;
  logic               take;

  assign older = !found_r || (ent_stamp < best_stamp_r);
  assign take  = ctrl.track && ent_valid && older;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r    <= 1'b0;
      best_idx_r <= '0;
    end else if (ctrl.clear) begin
      found_r    <= 1'b0;
      best_idx_r <= '0;
    end else if (take) begin
      found_r    <= 1'b1;
      best_idx_r <= idx;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      best_stamp_r <= ent_stamp;
      best_pid_r   <= ent_pid;
      best_page_r  <= ent_page;
    end
  end

  assign stat.pid_eq   = (ent_pid == key_pid);
  assign stat.page_eq  = (ent_page == key_page);
  assign stat.found    = found_r;
  assign stat.best_idx = best_idx_r;
  assign vic_pid       = best_pid_r;
  assign vic_page      = best_page_r;

endmodule

`default_nettype wire

### src/page_frame_table_lru.sv
// Frame table of a paged memory with least-recently-used replacement.
// Input words arrive on in_tvalid/in_tready/in_tdata and carry one of three
// requests: start a new process, access an address, or terminate a process.
// Each input word yields exactly one result word on out_tvalid/out_tready/
// out_tdata. The configuration port (cfg_we, cfg_index, cfg_wdata) sets the page
// shift and the frame limit; the user must write it only while the block is
// idle, which the block itself does not enforce. It works on one word at a
// time and scans the sixteen frames through a single compare unit, one frame
// per cycle. A new-process word goes straight to placement; an access scans
// until a hit, else places the page in a free frame or, after a second scan,
// over the least recently used entry; a terminate scans all frames. The block
// is ready once it loads the result and can take the next word the cycle after.
// The result register lets the next word be taken while a finished result
// waits; if the receiver stalls, the following result waits in its final state
// until the register is free. Reset empties the table and the free queue,
// clears the process and use counters, and sets the page shift to 12 and the
// frame limit to 16.
`default_nettype none

module page_frame_table_lru (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  // Fields from bit 0: func, proc_id, address, zero fill.
  input  wire logic [pft_pkg::IN_W-1:0]       in_tdata,
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  // Fields from bit 0: assigned_pid, frame_used, hit, evicted, victim_pid,
  // victim_page, freed_count, zero fill.
  output logic      [pft_pkg::OUT_W-1:0]      out_tdata,
  input  wire logic                           cfg_we,
  input  wire logic [pft_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [pft_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import pft_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_PLACE,
    ST_LRU,
    ST_WRITE,
    ST_DONE
  } state_t;

  state_t             state_r, state_nxt;
  logic [FRAME_W-1:0] idx_r, idx_nxt;
  logic [FUNC_W-1:0]  func_r, func_nxt;
  logic [PID_W-1:0]   key_pid_r, key_pid_nxt;
  logic [PAGE_W-1:0]  key_page_r, key_page_nxt;
  logic [CNT_W-1:0]   used_r, used_nxt;
  logic [PID_W-1:0]   next_pid_r, next_pid_nxt;
  logic [STAMP_W-1:0] use_cnt_r, use_cnt_nxt;
  logic [FRAME_W-1:0] frame_r, frame_nxt;
  logic               lru_mode_r, lru_mode_nxt;
  logic [FRAMES-1:0]  valid_r, valid_nxt;
  logic [FRAME_W-1:0] res_frame_r, res_frame_nxt;
  logic               res_hit_r, res_hit_nxt;
  logic               res_evicted_r, res_evicted_nxt;
  logic [PID_W-1:0]   res_vpid_r, res_vpid_nxt;
  logic [PAGE_W-1:0]  res_vpage_r, res_vpage_nxt;
  logic [CNT_W-1:0]   res_freed_r, res_freed_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0]   out_data_r, out_data_nxt;

  logic [SHIFT_W-1:0] page_shift_r;
  logic [LIMIT_W-1:0] frame_limit_r;
  logic [CNT_W-1:0]   limit;

  logic [PID_W-1:0]   ent_pid_r   [FRAMES];
  logic [PAGE_W-1:0]  ent_page_r  [FRAMES];
  logic [STAMP_W-1:0] ent_stamp_r [FRAMES];

  logic               ent_we;
  logic               stamp_we;
  logic [FRAME_W-1:0] ent_widx;

  scan_ctrl_t         scan_ctrl;
  scan_stat_t         scan_stat;
  logic [PID_W-1:0]   vic_pid;
  logic [PAGE_W-1:0]  vic_page;

  logic               q_push;
  logic               q_pop;
  logic [FRAME_W-1:0] q_head;
  logic [CNT_W-1:0]   q_count;

  logic [FUNC_W-1:0]  in_func;
  logic [PID_W-1:0]   in_pid;
  logic [ADDR_W-1:0]  in_addr;
  logic               last_idx;
  logic               in_fire;
  logic [FRAME_W-1:0] place_frame;

  assign in_func = in_tdata[1:0];
  assign in_pid  = in_tdata[17:2];
  assign in_addr = in_tdata[49:18];

  assign in_tready = (state_r == ST_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign last_idx  = (idx_r == FRAME_W'(FRAMES - 1));

  always_comb begin
    if (frame_limit_r == '0) begin
      limit = CNT_W'(1);
    end else if (CNT_W'(frame_limit_r) > CNT_W'(FRAMES)) begin
      limit = CNT_W'(FRAMES);
    end else begin
      limit = CNT_W'(frame_limit_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      page_shift_r  <= SHIFT_W'(12);
      frame_limit_r <= LIMIT_W'(16);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PAGE_SHIFT:  page_shift_r  <= cfg_wdata;
        CFG_FRAME_LIMIT: frame_limit_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  pft_scan_unit u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (scan_ctrl),
    .idx       (idx_r),
    .ent_valid (valid_r[idx_r]),
    .ent_pid   (ent_pid_r[idx_r]),
    .ent_page  (ent_page_r[idx_r]),
    .ent_stamp (ent_stamp_r[idx_r]),
    .key_pid   (key_pid_r),
    .key_page  (key_page_r),
    .stat      (scan_stat),
    .vic_pid   (vic_pid),
    .vic_page  (vic_page)
  );

  pft_free_q u_free_q (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_frame (idx_r),
    .pop        (q_pop),
    .head_frame (q_head),
    .count      (q_count)
  );

  assign place_frame = lru_mode_r ? scan_stat.best_idx : frame_r;

  always_comb begin
    state_nxt       = state_r;
    idx_nxt         = idx_r;
    func_nxt        = func_r;
    key_pid_nxt     = key_pid_r;
    key_page_nxt    = key_page_r;
    used_nxt        = used_r;
    next_pid_nxt    = next_pid_r;
    use_cnt_nxt     = use_cnt_r;
    frame_nxt       = frame_r;
    lru_mode_nxt    = lru_mode_r;
    valid_nxt       = valid_r;
    res_frame_nxt   = res_frame_r;
    res_hit_nxt     = res_hit_r;
    res_evicted_nxt = res_evicted_r;
    res_vpid_nxt    = res_vpid_r;
    res_vpage_nxt   = res_vpage_r;
    res_freed_nxt   = res_freed_r;
    out_valid_nxt   = out_valid_r && !out_tready;
    out_data_nxt    = out_data_r;
    scan_ctrl       = '0;
    q_push          = 1'b0;
    q_pop           = 1'b0;
    ent_we          = 1'b0;
    stamp_we        = 1'b0;
    ent_widx        = idx_r;

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          func_nxt        = in_func;
          key_pid_nxt     = in_pid;
          key_page_nxt    = in_addr >> page_shift_r;
          idx_nxt         = '0;
          res_frame_nxt   = '0;
          res_hit_nxt     = 1'b0;
          res_evicted_nxt = 1'b0;
          res_vpid_nxt    = '0;
          res_vpage_nxt   = '0;
          res_freed_nxt   = '0;
          case (in_func)
            FUNC_NEW: begin
              key_pid_nxt  = next_pid_r;
              key_page_nxt = '0;
              next_pid_nxt = next_pid_r + PID_W'(1);
              state_nxt    = ST_PLACE;
            end
            FUNC_ACCESS, FUNC_TERM: state_nxt = ST_SCAN;
            default:                state_nxt = ST_DONE;
          endcase
        end
      end

      ST_SCAN: begin
        if (func_r == FUNC_ACCESS) begin
          if (valid_r[idx_r] && scan_stat.pid_eq && scan_stat.page_eq) begin
            stamp_we      = 1'b1;
            use_cnt_nxt   = use_cnt_r + STAMP_W'(1);
            res_frame_nxt = idx_r;
            res_hit_nxt   = 1'b1;
            state_nxt     = ST_DONE;
          end else if (last_idx) begin
            state_nxt = ST_PLACE;
          end else begin
            idx_nxt = idx_r + FRAME_W'(1);
          end
        end else begin
          if (valid_r[idx_r] && scan_stat.pid_eq) begin
            valid_nxt[idx_r] = 1'b0;
            q_push           = 1'b1;
            if (used_r != '0) begin
              used_nxt = used_r - CNT_W'(1);
            end
            res_freed_nxt = res_freed_r + CNT_W'(1);
          end
          if (last_idx) begin
            state_nxt = ST_DONE;
          end else begin
            idx_nxt = idx_r + FRAME_W'(1);
          end
        end
      end

      ST_PLACE: begin
        if ((used_r < limit) && ((q_count != '0) || (used_r < CNT_W'(FRAMES)))) begin
          if (q_count != '0) begin
            frame_nxt = q_head;
            q_pop     = 1'b1;
          end else begin
            frame_nxt = used_r[FRAME_W-1:0];
          end
          used_nxt     = used_r + CNT_W'(1);
          lru_mode_nxt = 1'b0;
          state_nxt    = ST_WRITE;
        end else begin
          scan_ctrl.clear = 1'b1;
          idx_nxt         = '0;
          lru_mode_nxt    = 1'b1;
          state_nxt       = ST_LRU;
        end
      end

      ST_LRU: begin
        scan_ctrl.track = 1'b1;
        if (last_idx) begin
          state_nxt = ST_WRITE;
        end else begin
          idx_nxt = idx_r + FRAME_W'(1);
        end
      end

      ST_WRITE: begin
        if (lru_mode_r) begin
          if (scan_stat.found) begin
            res_evicted_nxt = 1'b1;
            res_vpid_nxt    = vic_pid;
            res_vpage_nxt   = vic_page;
          end else begin
            used_nxt = used_r + CNT_W'(1);
          end
        end
        ent_we                 = 1'b1;
        ent_widx               = place_frame;
        valid_nxt[place_frame] = 1'b1;
        use_cnt_nxt            = use_cnt_r + STAMP_W'(1);
        res_frame_nxt          = place_frame;
        state_nxt              = ST_DONE;
      end

      ST_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {5'd0, res_freed_r, res_vpage_r, res_vpid_r, res_evicted_r,
                           res_hit_r, res_frame_r, key_pid_r};
          state_nxt     = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      idx_r       <= '0;
      func_r      <= '0;
      used_r      <= '0;
      next_pid_r  <= '0;
      use_cnt_r   <= '0;
      frame_r     <= '0;
      lru_mode_r  <= 1'b0;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
      out_data_r  <= '0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      func_r      <= func_nxt;
      used_r      <= used_nxt;
      next_pid_r  <= next_pid_nxt;
      use_cnt_r   <= use_cnt_nxt;
      frame_r     <= frame_nxt;
      lru_mode_r  <= lru_mode_nxt;
      valid_r     <= valid_nxt;
      out_valid_r <= out_valid_nxt;
      out_data_r  <= out_data_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_pid_r     <= key_pid_nxt;
    key_page_r    <= key_page_nxt;
    res_frame_r   <= res_frame_nxt;
    res_hit_r     <= res_hit_nxt;
    res_evicted_r <= res_evicted_nxt;
    res_vpid_r    <= res_vpid_nxt;
    res_vpage_r   <= res_vpage_nxt;
    res_freed_r   <= res_freed_nxt;
  end

  always_ff @(posedge clk) begin
    if (ent_we) begin
      ent_pid_r[ent_widx]   <= key_pid_r;
      ent_page_r[ent_widx]  <= key_page_r;
      ent_stamp_r[ent_widx] <= use_cnt_r;
    end else if (stamp_we) begin
      ent_stamp_r[ent_widx] <= use_cnt_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  a_used_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> ($countones(valid_r) == int'(used_r)))
    else $error("used frame count differs from the number of valid entries");

  a_queue_fits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |->
      (({1'b0, q_count} + {1'b0, used_r}) <= (CNT_W + 1)'(FRAMES)))
    else $error("free queue and used frames exceed the frame count");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_tready)
    else $error("input taken again before the previous word finished");

  a_hit_not_evict: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_data_r[20] && out_data_r[21]))
    else $error("result marks both a hit and an eviction");

  a_term_no_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_data_r[74:70] != '0)) |-> (out_data_r[21:16] == '0))
    else $error("terminate result carries frame or hit information");

endmodule

`default_nettype wire

### verif/page_frame_table_lru_tb.sv
module page_frame_table_lru_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pft_pkg::*;

  localparam logic [FUNC_W-1:0] FUNC_UNKNOWN = 2'd3;
  localparam int MAX_GAP = 8;
  localparam int SETTLE_CYCLES = 40;
  localparam int RANDOM_PHASES = 11;
  localparam int PHASE_ITEMS = 150;

  typedef struct {
    logic [FUNC_W-1:0] func;
    logic [PID_W-1:0]  pid;
    logic [ADDR_W-1:0] addr;
  } request_t;

  typedef struct {
    logic [PID_W-1:0]   assigned_pid;
    logic [FRAME_W-1:0] frame;
    logic               hit;
    logic               evicted;
    logic [PID_W-1:0]   victim_pid;
    logic [PAGE_W-1:0]  victim_page;
    logic [CNT_W-1:0]   freed;
  } frame_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  // Fields from bit 0: func, proc_id, address, zero fill.
  logic [IN_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  // Fields from bit 0: assigned_pid, frame_used, hit, evicted, victim_pid,
  // victim_page, freed_count, zero fill.
  logic [OUT_W-1:0] out_tdata;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_PAGE_SHIFT;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  page_frame_table_lru uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always #2 clk = ~clk;

  // Shadow copy of the frame table.
  logic               tbl_valid [FRAMES];
  logic [PID_W-1:0]   tbl_pid   [FRAMES];
  logic [PAGE_W-1:0]  tbl_page  [FRAMES];
  logic [STAMP_W-1:0] tbl_stamp [FRAMES];
  logic [FRAME_W-1:0] free_frames [$];
  int                 used_cnt;
  logic [PID_W-1:0]   pid_next;
  logic [STAMP_W-1:0] use_count;
  logic [SHIFT_W-1:0] cur_shift = 5'd12;
  logic [LIMIT_W-1:0] cur_limit = 5'd16;

  frame_result_t frame_results_due [$];
  frame_result_t due_now;
  request_t      request_q [$];
  request_t      next_req;
  logic [PID_W-1:0] live_pids [$];
  logic [PID_W-1:0] gen_pid_next = '0;
  int issued = 0;
  int results_got = 0;
  int results_seen = 0;
  int err_count = 0;
  int send_gap = 0;
  int stall_left = 0;
  bit send_burst = 1'b0;
  bit recv_burst = 1'b0;
  logic in_took = 1'b0;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t: mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
    err_count++;
  endtask

  function automatic logic [FRAME_W-1:0] place_page(input logic [PID_W-1:0] pid,
                                                   input logic [PAGE_W-1:0] page,
                                                   inout frame_result_t r);
    logic [FRAME_W-1:0] f;
    logic found;
    int lim;
    f = '0;
    found = 1'b0;
    lim = (cur_limit == 0) ? 1 : (cur_limit > FRAMES) ? FRAMES : int'(cur_limit);
    if (used_cnt < lim && (free_frames.size() > 0 || used_cnt < FRAMES)) begin
      if (free_frames.size() > 0) begin
        f = free_frames.pop_front();
      end else begin
        f = FRAME_W'(used_cnt);
      end
      used_cnt++;
    end else begin
      for (int i = 0; i < FRAMES; i++) begin
        if (tbl_valid[i] && (!found || tbl_stamp[i] < tbl_stamp[f])) begin
          f = FRAME_W'(i);
          found = 1'b1;
        end
      end
      if (found) begin
        r.evicted = 1'b1;
        r.victim_pid = tbl_pid[f];
        r.victim_page = tbl_page[f];
      end else begin
        used_cnt++;
      end
    end
    tbl_valid[f] = 1'b1;
    tbl_pid[f] = pid;
    tbl_page[f] = page;
    tbl_stamp[f] = use_count;
    use_count++;
    return f;
  endfunction

  function automatic frame_result_t frame_table_step(input request_t q);
    frame_result_t r;
    logic [PAGE_W-1:0] page;
    logic found;
    r = '{default: '0};
    r.assigned_pid = q.pid;
    found = 1'b0;
    case (q.func)
      FUNC_NEW: begin
        r.assigned_pid = pid_next;
        r.frame = place_page(pid_next, '0, r);
        pid_next++;
      end
      FUNC_ACCESS: begin
        page = q.addr >> cur_shift;
        for (int i = 0; i < FRAMES; i++) begin
          if (!found && tbl_valid[i] && tbl_pid[i] == q.pid && tbl_page[i] == page) begin
            tbl_stamp[i] = use_count;
            use_count++;
            r.frame = FRAME_W'(i);
            r.hit = 1'b1;
            found = 1'b1;
          end
        end
        if (!found) begin
          r.frame = place_page(q.pid, page, r);
        end
      end
      FUNC_TERM: begin
        for (int i = 0; i < FRAMES; i++) begin
          if (tbl_valid[i] && tbl_pid[i] == q.pid) begin
            tbl_valid[i] = 1'b0;
            if (free_frames.size() < FRAMES) begin
              free_frames = {free_frames, FRAME_W'(i)};
            end
            if (used_cnt > 0) begin
              used_cnt--;
            end
            r.freed++;
          end
        end
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  // Prediction at input acceptance and checking at output acceptance.
  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < FRAMES; i++) begin
        tbl_valid[i] = 1'b0;
        tbl_pid[i] = '0;
        tbl_page[i] = '0;
        tbl_stamp[i] = '0;
      end
      free_frames.delete();
      frame_results_due.delete();
      used_cnt = 0;
      pid_next = '0;
      use_count = '0;
      in_took <= 1'b0;
    end else begin
      in_took <= in_tvalid && in_tready;
      if (out_tvalid && out_tready) begin
        results_got++;
        if (frame_results_due.size() == 0) begin
          report_mismatch("word with nothing expected", out_tdata[31:0], '0);
        end else begin
          due_now = frame_results_due.pop_front();
          if (out_tdata[15:0] !== due_now.assigned_pid)
            report_mismatch("assigned_pid", out_tdata[15:0], due_now.assigned_pid);
          if (out_tdata[19:16] !== due_now.frame)
            report_mismatch("frame_used", out_tdata[19:16], due_now.frame);
          if (out_tdata[20] !== due_now.hit)
            report_mismatch("hit", out_tdata[20], due_now.hit);
          if (out_tdata[21] !== due_now.evicted)
            report_mismatch("evicted", out_tdata[21], due_now.evicted);
          if (out_tdata[37:22] !== due_now.victim_pid)
            report_mismatch("victim_pid", out_tdata[37:22], due_now.victim_pid);
          if (out_tdata[69:38] !== due_now.victim_page)
            report_mismatch("victim_page", out_tdata[69:38], due_now.victim_page);
          if (out_tdata[74:70] !== due_now.freed)
            report_mismatch("freed_count", out_tdata[74:70], due_now.freed);
        end
      end
      if (in_tvalid && in_tready) begin
        frame_results_due = {frame_results_due,
                             frame_table_step('{func: in_tdata[1:0],
                                                pid: in_tdata[17:2],
                                                addr: in_tdata[49:18]})};
      end
    end
  end

  // Request driver.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      send_gap = 0;
    end else if (!in_tvalid || in_took) begin
      if (in_tvalid) begin
        if ($urandom_range(0, 29) == 0) send_burst = !send_burst;
        send_gap = send_burst ? 0 : $urandom_range(0, MAX_GAP);
      end
      if (send_gap > 0) begin
        send_gap--;
        in_tvalid <= 1'b0;
      end else if (request_q.size() != 0) begin
        next_req = request_q.pop_front();
        in_tdata <= {6'b0, next_req.addr, next_req.pid, next_req.func};
        in_tvalid <= 1'b1;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Result receiver with random back-pressure.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      stall_left = 0;
    end else begin
      if (results_got != results_seen) begin
        results_seen = results_got;
        if ($urandom_range(0, 29) == 0) recv_burst = !recv_burst;
        stall_left = recv_burst ? 0 : $urandom_range(0, MAX_GAP);
      end
      if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  task automatic add_request(input logic [FUNC_W-1:0] func, input logic [PID_W-1:0] pid,
                             input logic [ADDR_W-1:0] addr);
    if (func == FUNC_NEW) begin
      live_pids = {live_pids, gen_pid_next};
      gen_pid_next++;
    end
    request_q = {request_q, request_t'{func: func, pid: pid, addr: addr}};
    issued++;
  endtask

  task automatic add_random_request();
    int roll;
    int k;
    logic [ADDR_W-1:0] low_mask;
    roll = $urandom_range(0, 99);
    low_mask = (32'h1 << cur_shift) - 32'h1;
    if (roll >= 86) begin
      add_request(FUNC_W'($urandom_range(0, 3)), PID_W'($urandom), $urandom);
    end else if (live_pids.size() == 0 || (roll < 10 && live_pids.size() < 10)) begin
      add_request(FUNC_NEW, PID_W'($urandom), $urandom);
    end else begin
      k = $urandom_range(0, live_pids.size() - 1);
      if (roll < 78) begin
        add_request(FUNC_ACCESS, live_pids[k],
                    (32'($urandom_range(0, 5)) << cur_shift) | ($urandom & low_mask));
      end else begin
        add_request(FUNC_TERM, live_pids[k], $urandom);
        live_pids.delete(k);
      end
    end
  endtask

  task automatic wait_idle();
    while (results_got != issued) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_config(input logic [SHIFT_W-1:0] shift, input logic [LIMIT_W-1:0] limit);
    cfg_we <= 1'b1;
    cfg_index <= CFG_PAGE_SHIFT;
    cfg_wdata <= shift;
    cur_shift = shift;
    @(negedge clk);
    cfg_index <= CFG_FRAME_LIMIT;
    cfg_wdata <= limit;
    cur_limit = limit;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
    @(posedge clk);
  endtask

  initial begin
    int shift_plan [5];
    int limit_plan [5];
    shift_plan = '{20, 31, 0, 12, 5};
    limit_plan = '{16, 1, 31, 2, 16};
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Page 0 of pid 0 is mapped before that pid is handed out, so the later
    // lookup matches two frames.
    add_request(FUNC_ACCESS, 16'h0000, 32'h0000_0000);
    add_request(FUNC_NEW, 16'hFFFF, 32'hFFFF_FFFF);
    add_request(FUNC_ACCESS, 16'h0000, 32'h0000_0FFF);
    add_request(FUNC_TERM, 16'hFFFF, 32'h0000_0000);
    add_request(FUNC_UNKNOWN, 16'hFFFF, 32'hFFFF_FFFF);
    add_request(FUNC_ACCESS, 16'hFFFF, 32'hFFFF_FFFF);
    add_request(FUNC_NEW, 16'h0000, 32'h0000_0000);
    add_request(FUNC_ACCESS, 16'hFFFF, 32'hFFFF_F000);
    add_request(FUNC_TERM, 16'h0000, 32'hFFFF_FFFF);
    add_request(FUNC_NEW, 16'h1234, 32'h0000_0000);
    add_request(FUNC_ACCESS, 16'h0001, 32'h0000_5000);
    wait_idle();

    // An out-of-range limit of zero also drops the limit below current use.
    write_config(5'd0, 5'd0);
    add_request(FUNC_ACCESS, 16'h0001, 32'h0000_0007);
    add_request(FUNC_ACCESS, 16'h0001, 32'h0000_0007);
    add_request(FUNC_ACCESS, 16'h0002, 32'hFFFF_FFFF);
    add_request(FUNC_NEW, 16'h0000, 32'h0000_0000);
    add_request(FUNC_TERM, 16'hFFFF, 32'h0000_0000);
    add_request(FUNC_TERM, 16'h0001, 32'h0000_0000);
    add_request(FUNC_ACCESS, 16'h8000, 32'h8000_0000);
    add_request(FUNC_UNKNOWN, 16'h0000, 32'h0000_0000);
    wait_idle();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      if (p < 5) begin
        write_config(SHIFT_W'(shift_plan[p]), LIMIT_W'(limit_plan[p]));
      end else begin
        write_config(SHIFT_W'($urandom_range(0, 31)), LIMIT_W'($urandom_range(0, 31)));
      end
      repeat (PHASE_ITEMS) add_random_request();
      wait_idle();
    end

    if (frame_results_due.size() != 0) begin
      report_mismatch("words still expected at end", frame_results_due.size(), '0);
    end
    if (err_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
